@@ rtl/flc_pkg.sv @@
// Shared types, widths and command codes for the FIR linear convolution block.
package flc_pkg;

   localparam int MAX_TAPS  = 64;
   localparam int IDX_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CMP_W     = IDX_W + 8;
   localparam int DATA_W    = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = 40;
   localparam int CMD_W     = 2;
   localparam int CIDX_W    = 6;
   localparam int TAPS_W    = 7;

   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [CIDX_W-1:0]        cidx_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [TAPS_W-1:0]        taps_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CMP_W-1:0]         cmp_type;

   localparam cmd_type CMD_LOAD   = 2'd0;
   localparam cmd_type CMD_SAMPLE = 2'd1;
   localparam cmd_type CMD_FLUSH  = 2'd2;
   localparam cmd_type CMD_CLEAR  = 2'd3;

   localparam taps_type TAP_COUNT_RESET = 7'd64;
   localparam idx_type  LAST_IDX        = idx_type'(MAX_TAPS - 1);

   // Control of one cell of the tap ring
   typedef struct packed {
      logic shift;
      logic rotate;
      logic clear;
      logic load;
   } cell_ctl_type;

   // Control of the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic en;
      logic mask;
   } mac_ctl_type;

endpackage

@@ rtl/flc_if.sv @@
// Request and response channel interfaces of the FIR linear convolution block.
interface flc_req_if;
   logic               valid;
   logic               ready;
   flc_pkg::cmd_type   cmd;
   flc_pkg::cidx_type  coef_index;
   flc_pkg::data_type  coef_value;
   flc_pkg::data_type  sample_value;

   modport source (output valid, output cmd, output coef_index, output coef_value,
                   output sample_value, input ready);
   modport sink   (input valid, input cmd, input coef_index, input coef_value,
                   input sample_value, output ready);
endinterface

interface flc_rsp_if;
   logic              valid;
   logic              ready;
   flc_pkg::acc_type  output_value;
   logic              is_tail;

   modport source (output valid, output output_value, output is_tail, input ready);
   modport sink   (input valid, input output_value, input is_tail, output ready);
endinterface

@@ rtl/fir_linear_convolution.sv @@
// Top level of the FIR linear convolution block: tap ring, MAC and sequencer.
//
// Usage: transactions arrive on the req channel (valid/ready) and carry a
// command. A load writes one kernel coefficient, a clear zeroes the delay
// line; both complete on acceptance and give no response. A sample shifts the sample
// into the delay line, a flush shifts in zero; each gives one response on the
// rsp channel with the exact 40-bit sum of products and is_tail set for flush.
// The csr port writes tap_count (taps at or above it count as zero).
// The taps sit in a ring of MAX_TAPS cells. After a shift the ring rotates
// once around, one tap per cycle through a single multiplier and a 40-bit
// accumulator; the sequencer then passes an add state and a done state, in
// which the response is loaded. req.ready is low until the sequencer is idle
// again, so a new sample or flush is only taken once the last one is done.
// The response sits in an output register; the next transaction is accepted
// while it waits, and the sequencer holds the new result until rsp.ready has
// emptied that register.
// Reset (synchronous, active high) zeroes the delay line, sets tap_count to
// 64 and empties the output register; coefficients hold no reset value and
// must be loaded before use.
module fir_linear_convolution (
   input  logic                 clock,
   input  logic                 reset,
   flc_req_if.sink              req,
   flc_rsp_if.source            rsp,
   input  logic                 csr_wr_en,
   input  flc_pkg::taps_type    csr_wr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]             state_ff, state_in;
   flc_pkg::idx_type       cnt_ff, cnt_in;
   flc_pkg::taps_type      taps_ff, taps_in;
   logic                   tail_ff, tail_in;
   logic                   out_valid_ff, out_valid_in;
   flc_pkg::acc_type       out_value_ff;
   logic                   out_tail_ff;
   logic                   take;
   logic                   load_out;
   flc_pkg::cell_ctl_type  cell_ctl;
   flc_pkg::mac_ctl_type   mac_ctl;
   flc_pkg::data_type      push_val;
   flc_pkg::acc_type       acc;
   flc_pkg::data_type      d_bus [flc_pkg::MAX_TAPS];
   flc_pkg::data_type      k_bus [flc_pkg::MAX_TAPS];

   assign req.ready = (state_ff == ST_IDLE);
   assign take      = req.valid && req.ready;
   assign push_val  = (req.cmd == flc_pkg::CMD_SAMPLE) ? req.sample_value : '0;

   // Write or hold the tap count register
   assign taps_in = csr_wr_en ? csr_wr_data : taps_ff;

   // Sequence one transaction through the ring and the MAC
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      tail_in  = tail_ff;
      load_out = 1'b0;
      cell_ctl = '0;
      mac_ctl  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (req.cmd)
                  flc_pkg::CMD_LOAD: begin
                     cell_ctl.load = 1'b1;
                  end
                  flc_pkg::CMD_CLEAR: begin
                     cell_ctl.clear = 1'b1;
                  end
                  default: begin
                     cell_ctl.shift = 1'b1;
                     mac_ctl.clear  = 1'b1;
                     tail_in        = (req.cmd == flc_pkg::CMD_FLUSH);
                     cnt_in         = '0;
                     state_in       = ST_RUN;
                  end
               endcase
            end
         end
         ST_RUN: begin
            cell_ctl.rotate = 1'b1;
            mac_ctl.en      = 1'b1;
            mac_ctl.mask    = (flc_pkg::cmp_type'(cnt_ff) < flc_pkg::cmp_type'(taps_ff));
            if (cnt_ff == flc_pkg::LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_ADD;
            end else begin
               cnt_in = cnt_ff + flc_pkg::idx_type'(1);
            end
         end
         ST_ADD: begin
            state_in = ST_DONE;
         end
         default: begin
            if (!out_valid_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Fill or drain the output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         taps_ff      <= flc_pkg::TAP_COUNT_RESET;
         tail_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         taps_ff      <= taps_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_value_ff <= acc;
         out_tail_ff  <= tail_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.output_value = out_value_ff;
   assign rsp.is_tail      = out_tail_ff;

   // Build the ring: shift from the previous cell, rotate from the next
   for (genvar i = 0; i < flc_pkg::MAX_TAPS; i++) begin : g_cell
      localparam int NXT = (i + 1) % flc_pkg::MAX_TAPS;
      localparam int PRV = (i == 0) ? 0 : i - 1;
      flc_pkg::data_type shift_src;

      assign shift_src = (i == 0) ? push_val : d_bus[PRV];

      flc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .cell_idx   (flc_pkg::idx_type'(i)),
         .load_index (req.coef_index),
         .load_value (req.coef_value),
         .shift_d    (shift_src),
         .rot_d      (d_bus[NXT]),
         .rot_k      (k_bus[NXT]),
         .d_out      (d_bus[i]),
         .k_out      (k_bus[i])
      );
   end

   flc_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a     (d_bus[0]),
      .b     (k_bus[0]),
      .acc   (acc)
   );

`ifndef SYNTHESIS
   // The ring counter sits at home whenever a transaction can be taken
   a_home_when_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> cnt_ff == '0)
      else $error("tap counter not at home while ready");

   // The last rotation is followed by the final accumulate cycle
   a_run_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff == flc_pkg::LAST_IDX) |=> state_ff == ST_ADD)
      else $error("rotation did not end after the last tap");

   // A waiting result is never overwritten by the next one
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_valid_ff && !rsp.ready) |=> state_ff == ST_DONE)
      else $error("result left the sequencer while the output register was full");

   // Loads and clears finish in the cycle they are accepted
   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (take && (req.cmd == flc_pkg::CMD_LOAD || req.cmd == flc_pkg::CMD_CLEAR))
      |=> state_ff == ST_IDLE)
      else $error("load or clear started a ring pass");
`endif

endmodule

@@ rtl/flc_cell.sv @@
// One tap cell: holds one delay line entry and one coefficient of the ring.
module flc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  flc_pkg::cell_ctl_type  ctl,
   input  flc_pkg::idx_type       cell_idx,
   input  flc_pkg::cidx_type      load_index,
   input  flc_pkg::data_type      load_value,
   input  flc_pkg::data_type      shift_d,
   input  flc_pkg::data_type      rot_d,
   input  flc_pkg::data_type      rot_k,
   output flc_pkg::data_type      d_out,
   output flc_pkg::data_type      k_out
);

   flc_pkg::data_type d_ff, d_in;
   flc_pkg::data_type k_ff, k_in;
   logic              hit;

   // Match the load address against this cell's position
   assign hit = (flc_pkg::cmp_type'(load_index) == flc_pkg::cmp_type'(cell_idx));

   // Select the next delay entry: clear, shift in, or rotate
   always_comb begin
      d_in = d_ff;
      if (ctl.clear) begin
         d_in = '0;
      end else if (ctl.shift) begin
         d_in = shift_d;
      end else if (ctl.rotate) begin
         d_in = rot_d;
      end
   end

   // Select the next coefficient: load or rotate
   always_comb begin
      k_in = k_ff;
      if (ctl.load && hit) begin
         k_in = load_value;
      end else if (ctl.rotate) begin
         k_in = rot_k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else begin
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
   end

   assign d_out = d_ff;
   assign k_out = k_ff;

endmodule

@@ rtl/flc_mac.sv @@
// Multiply-accumulate unit: registered product, then a 40-bit running sum.
module flc_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  flc_pkg::mac_ctl_type  ctl,
   input  flc_pkg::data_type     a,
   input  flc_pkg::data_type     b,
   output flc_pkg::acc_type      acc
);

   flc_pkg::prod_type p_ff, p_in;
   logic              pv_ff, pv_in;
   flc_pkg::acc_type  acc_ff, acc_in;

   // Multiply at full product width; drop taps beyond the count in use
   assign p_in  = (ctl.en && ctl.mask) ? flc_pkg::prod_type'(a) * flc_pkg::prod_type'(b) : '0;
   assign pv_in = ctl.en && !ctl.clear;

   // Accumulate the registered product, wrapping at 40 bits
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         acc_in = acc_ff + {{(flc_pkg::ACC_W - flc_pkg::PROD_W){p_ff[flc_pkg::PROD_W-1]}},
                            p_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
